@@ design/bit_range_packer_assert.svh @@
// Assertion shorthands used by the checker file.
`ifndef BIT_RANGE_PACKER_ASSERT_SVH
`define BIT_RANGE_PACKER_ASSERT_SVH

// Same-cycle implication, reset masks the check.
`define BRP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masks the check.
`define BRP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/brp_pkg.sv @@
package brp_pkg;

  localparam int unsigned QueueDepthDef = 2;
  localparam logic [7:0]  AllOnes       = 8'hFF;
  localparam logic [6:0]  PartOnes      = 7'h7F;
  localparam logic [3:0]  ByteBits      = 4'd8;

  // Classified word: kept bits right-aligned, their number, flush flag.
  typedef struct packed {
    logic [7:0] bits;
    logic [3:0] take;
    logic       eop;
  } brp_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } brp_q_stat_t;

endpackage

@@ design/brp_if.sv @@
interface brp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;
  logic [2:0] bit_offset;
  logic [3:0] bit_count;
  logic       end_of_packet;

  modport source (output valid, src_byte, bit_offset, bit_count, end_of_packet,
                  input ready);
  modport sink   (input valid, src_byte, bit_offset, bit_count, end_of_packet,
                  output ready);
endinterface

interface brp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_last;

  modport source (output valid, out_byte, is_last, input ready);
  modport sink   (input valid, out_byte, is_last, output ready);
endinterface

@@ design/brp_front.sv @@
module brp_front import brp_pkg::*; (
  brp_in_if.sink     in_ch_i,
  input  brp_q_stat_t q_stat_i,
  output logic        push_o,
  output brp_item_t   item_o
);

  logic [3:0] room;
  logic [3:0] take;
  logic [3:0] shift;
  logic [7:0] shifted;

  // Clip the count at the byte end, then right-align the kept bits.
  always_comb begin
    room    = ByteBits - {1'b0, in_ch_i.bit_offset};
    take    = (in_ch_i.bit_count < room) ? in_ch_i.bit_count : room;
    shift   = room - take;
    shifted = in_ch_i.src_byte >> shift;
  end

  assign item_o.bits = shifted & ~(AllOnes << take);
  assign item_o.take = take;
  assign item_o.eop  = in_ch_i.end_of_packet;

  assign in_ch_i.ready = !q_stat_i.full;
  assign push_o        = in_ch_i.valid && !q_stat_i.full;

endmodule

@@ design/brp_queue.sv @@
module brp_queue import brp_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  brp_item_t   item_i,
  input  logic        pop_i,
  output brp_q_stat_t stat_o,
  output brp_item_t   item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  brp_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ design/brp_back.sv @@
module brp_back import brp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  brp_q_stat_t q_stat_i,
  input  brp_item_t   item_i,
  output logic        pop_o,
  brp_out_if.source   out_ch_o
);

  logic [6:0]  partial_q;
  logic [2:0]  pend_q;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  logic        held_valid_q;
  logic [7:0]  held_byte_q;

  logic        out_free;
  logic [14:0] acc;
  logic [3:0]  total;
  logic [2:0]  nb;
  logic        full_byte;
  logic [14:0] done_w;
  logic [6:0]  keep;
  logic [14:0] pad_w;
  logic        has_pad;

  assign out_free = !out_valid_q || out_ch_o.ready;
  assign pop_o    = !q_stat_i.empty && !held_valid_q && out_free;

  // Merge the word into the accumulator; low three bits of the sum are what stays.
  always_comb begin
    acc       = ({8'b0, partial_q} << item_i.take) | {7'b0, item_i.bits};
    total     = {1'b0, pend_q} + item_i.take;
    full_byte = total[3];
    nb        = total[2:0];
    done_w    = acc >> nb;
    keep      = acc[6:0] & ~(PartOnes << nb);
    pad_w     = {keep, AllOnes} >> nb;
    has_pad   = item_i.eop && (nb != 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q    <= '0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
      out_byte_q   <= '0;
      out_last_q   <= 1'b0;
      held_valid_q <= 1'b0;
      held_byte_q  <= '0;
    end else begin
      priority if (held_valid_q && out_free) begin
        out_valid_q  <= 1'b1;
        out_byte_q   <= held_byte_q;
        out_last_q   <= 1'b1;
        held_valid_q <= 1'b0;
      end else if (pop_o) begin
        partial_q <= item_i.eop ? 7'd0 : keep;
        pend_q    <= item_i.eop ? 3'd0 : nb;
        if (full_byte) begin
          out_valid_q  <= 1'b1;
          out_byte_q   <= done_w[7:0];
          out_last_q   <= item_i.eop && !has_pad;
          held_valid_q <= has_pad;
          held_byte_q  <= pad_w[7:0];
        end else if (has_pad) begin
          out_valid_q <= 1'b1;
          out_byte_q  <= pad_w[7:0];
          out_last_q  <= 1'b1;
        end else begin
          out_valid_q <= 1'b0;
        end
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end else begin
        // Hold the output word until the receiver takes it.
        out_valid_q <= out_valid_q;
      end
    end
  end

  assign out_ch_o.valid    = out_valid_q;
  assign out_ch_o.out_byte = out_byte_q;
  assign out_ch_o.is_last  = out_last_q;

endmodule

@@ design/bit_range_packer.sv @@
// Channel   | Dir | Payload                                             | Role
// ----------+-----+-----------------------------------------------------+---------------------
// in_ch_i   | in  | src_byte, bit_offset, bit_count, end_of_packet      | bit ranges to append
// out_ch_o  | out | out_byte, is_last                                   | packed bytes
//
// Takes one word per cycle while the queue is not full; the back end turns one queued word
// per cycle into bytes while the output is free and no padded byte is held. A word that
// completes a byte and also flushes a padded one holds the back end until the padded byte
// reaches the output register, since the output carries one byte per cycle. A byte reaches
// out_ch_o through the queue and then the output register.
// Reset clears the queue, the accumulator and both output registers.
// A stalled output fills the queue; in_ch_i.ready drops only once it is full.
module bit_range_packer import brp_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  brp_in_if.sink   in_ch_i,
  brp_out_if.source out_ch_o
);

  logic        push;
  logic        pop;
  brp_item_t   front_item;
  brp_item_t   back_item;
  brp_q_stat_t q_stat;

  // Front: clip the range and right-align the kept bits.
  brp_front u_front (
    .in_ch_i  (in_ch_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .item_o   (front_item)
  );

  // Short queue: lets the front keep accepting while the back end waits on output.
  brp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .stat_o (q_stat),
    .item_o (back_item)
  );

  // Back: accumulate, emit completed bytes, pad with ones on end of packet.
  brp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .item_i   (back_item),
    .pop_o    (pop),
    .out_ch_o (out_ch_o)
  );

endmodule

@@ design/brp_checker.sv @@
`include "bit_range_packer_assert.svh"

module brp_checker import brp_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       is_last_i
);

  // Enough cycles to drain a full queue plus both output registers.
  localparam logic [3:0] DrainCycles = 4'(2 * QueueDepthDef + 4);

  logic [3:0] idle_q, idle_d;

  always_comb begin
    idle_d = idle_q;
    if ((in_valid_i && in_ready_i) || !out_ready_i) begin
      idle_d = '0;
    end else if (idle_q != 4'hF) begin
      idle_d = idle_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q <= '0;
    end else begin
      idle_q <= idle_d;
    end
  end

  `BRP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_byte_i) && $stable(is_last_i), "stalled output word changed")
  `BRP_ASSERT_NOW(a_full_means_stall, clk_i, rst_ni, !in_ready_i, out_valid_i, "input blocked without a pending output word")
  `BRP_ASSERT_NOW(a_drains, clk_i, rst_ni, idle_q >= DrainCycles, !out_valid_i, "output still busy after drain time")

endmodule

bind bit_range_packer brp_checker u_brp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch_i.valid),
  .in_ready_i  (in_ch_i.ready),
  .out_valid_i (out_ch_o.valid),
  .out_ready_i (out_ch_o.ready),
  .out_byte_i  (out_ch_o.out_byte),
  .is_last_i   (out_ch_o.is_last)
);

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  // One packed byte as it leaves the block.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_last;
  } packed_byte_t;

  // Everything that one accepted word produces: none, one or two bytes.
  typedef struct packed {
    logic [1:0]   count;
    packed_byte_t first;
    packed_byte_t second;
  } word_result_t;

  // One row of the directed table. Rows with typed set carry their bytes by hand.
  typedef struct {
    logic [7:0]   src;
    logic [2:0]   off;
    logic [3:0]   cnt;
    logic         eop;
    bit           typed;
    word_result_t want;
  } stim_row_t;

  // Patterns for the byte receiver's ready line.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_ONE_IN_FOUR,
    STALL_HEAVY
  } stall_mode_e;

  localparam int unsigned RandomWords = 1750;
  localparam int unsigned DrainCycles = 16;

  logic clk;
  logic rst_n;

  brp_in_if  in_ch ();
  brp_out_if out_ch ();

  bit_range_packer u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch)
  );

  // Own copy of the packer's accumulator.
  logic [6:0] held_bits;
  logic [2:0] held_count;

  packed_byte_t expected_bytes[$];
  stim_row_t    stim_rows[$];

  int unsigned burst_left;
  int unsigned words_sent;
  int unsigned bytes_checked;
  int unsigned packet_ends;
  int unsigned double_words;
  int unsigned mismatches;

  stall_mode_e stall_mode;
  int unsigned stall_left;
  int unsigned stall_phase;

  always #2 clk = ~clk;

  // Work out the bytes that one word causes and advance the held bits.
  function automatic word_result_t predict_word(input logic [7:0] src, input logic [2:0] off,
                                                input logic [3:0] cnt, input logic eop);
    word_result_t r;
    int unsigned  room;
    int unsigned  take;
    int unsigned  bits;
    int unsigned  acc;
    int unsigned  total;
    int unsigned  rest;
    int unsigned  pad;
    r     = '0;
    // Clip the count at the LSB of the source byte, whatever the count field says.
    room  = 8 - off;
    take  = (cnt < room) ? cnt : room;
    bits  = (src >> (room - take)) & ((1 << take) - 1);
    acc   = (held_bits << take) | bits;
    total = held_count + take;
    if (total >= 8) begin
      rest             = total - 8;
      r.first.out_byte = 8'(acc >> rest);
      r.count          = 2'd1;
      acc              = acc & ((1 << rest) - 1);
      total            = rest;
    end
    held_bits  = 7'(acc);
    held_count = 3'(total);
    if (eop) begin
      if (held_count != 0) begin
        // Pad the partial byte with ones below its last bit and mark it last.
        pad = 8 - held_count;
        if (r.count == 2'd1) begin
          r.second.out_byte = 8'((held_bits << pad) | ((1 << pad) - 1));
          r.second.is_last  = 1'b1;
        end else begin
          r.first.out_byte = 8'((held_bits << pad) | ((1 << pad) - 1));
          r.first.is_last  = 1'b1;
        end
        r.count = r.count + 2'd1;
      end else if (r.count == 2'd1) begin
        r.first.is_last = 1'b1;
      end
      held_bits  = '0;
      held_count = '0;
    end
    return r;
  endfunction

  function automatic void add_row(input logic [7:0] src, input logic [2:0] off,
                                  input logic [3:0] cnt, input logic eop, input bit typed,
                                  input logic [1:0] n, input logic [7:0] b0, input logic l0,
                                  input logic [7:0] b1, input logic l1);
    stim_row_t row;
    row.src  = src;
    row.off  = off;
    row.cnt  = cnt;
    row.eop  = eop;
    row.typed = typed;
    row.want = '{count: n, first: '{b0, l0}, second: '{b1, l1}};
    stim_rows.push_back(row);
  endfunction

  function automatic void queue_bytes(input word_result_t r);
    if (r.count >= 2'd1) expected_bytes.push_back(r.first);
    if (r.count == 2'd2) begin
      expected_bytes.push_back(r.second);
      double_words++;
    end
  endfunction

  // Offer one word, hold it until taken, then return the predicted bytes.
  // Drop valid for a random gap whenever the current burst runs out.
  task automatic send_word(input logic [7:0] src, input logic [2:0] off, input logic [3:0] cnt,
                           input logic eop, output word_result_t r);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // Now and then run a long burst so that stretches with no gaps occur.
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    in_ch.valid         <= 1'b1;
    in_ch.src_byte      <= src;
    in_ch.bit_offset    <= off;
    in_ch.bit_count     <= cnt;
    in_ch.end_of_packet <= eop;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    words_sent++;
    r = predict_word(src, off, cnt, eop);
  endtask

  // Hold the sender idle until every predicted byte has been seen.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  // Receiver: pick a stall pattern every so often and apply it cycle by cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (stall_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        stall_left = $urandom_range(20, 80);
      end
      stall_left--;
      stall_phase++;
      case (stall_mode)
        STALL_NONE:        out_ch.ready <= 1'b1;
        STALL_COIN:        out_ch.ready <= 1'($urandom_range(0, 1));
        STALL_ONE_IN_FOUR: out_ch.ready <= (stall_phase[1:0] == 2'd3);
        default:           out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Checker: compare every byte taken from the block with the oldest expectation.
  always @(posedge clk) begin
    packed_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual out_byte %02h is_last %0b",
                 $time, out_ch.out_byte, out_ch.is_last);
        mismatches++;
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (want.is_last) packet_ends++;
        if (out_ch.out_byte !== want.out_byte) begin
          $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                   $time, want.out_byte, out_ch.out_byte);
          mismatches++;
        end
        if (out_ch.is_last !== want.is_last) begin
          $display("%0t: is_last mismatch: expected %0b, actual %0b",
                   $time, want.is_last, out_ch.is_last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    word_result_t r;
    int unsigned  pkt_len;
    logic [3:0]   cnt;
    logic         eop;

    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.src_byte      = '0;
    in_ch.bit_offset    = '0;
    in_ch.bit_count     = '0;
    in_ch.end_of_packet = 1'b0;
    out_ch.ready        = 1'b0;
    held_bits           = '0;
    held_count          = '0;
    burst_left          = 0;
    stall_left          = 0;
    stall_phase         = 0;
    stall_mode          = STALL_NONE;

    // Directed table. Typed rows all start from an empty stream.
    //      src    off   cnt    eop  typed n     byte0  last0 byte1 last1
    add_row(8'hFF, 3'd0, 4'd8,  1'b0, 1, 2'd1, 8'hFF, 1'b0, 8'h00, 1'b0); // full byte
    add_row(8'h00, 3'd0, 4'd8,  1'b1, 1, 2'd1, 8'h00, 1'b1, 8'h00, 1'b0); // completes, marked last
    add_row(8'hA5, 3'd0, 4'd0,  1'b1, 1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0); // flush of empty stream
    add_row(8'h00, 3'd0, 4'd1,  1'b1, 1, 2'd1, 8'h7F, 1'b1, 8'h00, 1'b0); // one zero, ones padding
    add_row(8'h96, 3'd0, 4'd15, 1'b0, 1, 2'd1, 8'h96, 1'b0, 8'h00, 1'b0); // count above eight
    add_row(8'hFF, 3'd7, 4'd15, 1'b0, 0, '0, '0, '0, '0, '0);             // clipped to the LSB
    add_row(8'h3C, 3'd2, 4'd8,  1'b0, 0, '0, '0, '0, '0, '0);             // past the byte end
    add_row(8'hC3, 3'd0, 4'd9,  1'b1, 0, '0, '0, '0, '0, '0);             // completed plus padded
    add_row(8'h55, 3'd4, 4'd4,  1'b0, 0, '0, '0, '0, '0, '0);
    add_row(8'hAA, 3'd0, 4'd4,  1'b1, 0, '0, '0, '0, '0, '0);             // exact fill at flush
    add_row(8'h7E, 3'd5, 4'd3,  1'b0, 0, '0, '0, '0, '0, '0);
    add_row(8'h12, 3'd3, 4'd2,  1'b0, 0, '0, '0, '0, '0, '0);
    add_row(8'h5A, 3'd0, 4'd0,  1'b1, 0, '0, '0, '0, '0, '0);             // zero count still flushes
    add_row(8'hF0, 3'd1, 4'd7,  1'b0, 0, '0, '0, '0, '0, '0);
    add_row(8'h0F, 3'd6, 4'd12, 1'b0, 0, '0, '0, '0, '0, '0);
    add_row(8'h81, 3'd7, 4'd1,  1'b0, 0, '0, '0, '0, '0, '0);
    add_row(8'h00, 3'd7, 4'd8,  1'b0, 0, '0, '0, '0, '0, '0);
    add_row(8'hE7, 3'd4, 4'd13, 1'b1, 0, '0, '0, '0, '0, '0);
    add_row(8'hFF, 3'd0, 4'd8,  1'b1, 1, 2'd1, 8'hFF, 1'b1, 8'h00, 1'b0);
    add_row(8'h01, 3'd0, 4'd8,  1'b0, 1, 2'd1, 8'h01, 1'b0, 8'h00, 1'b0);

    // Hold reset, then release it just after a rising clock edge.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      send_word(stim_rows[i].src, stim_rows[i].off, stim_rows[i].cnt, stim_rows[i].eop, r);
      queue_bytes(stim_rows[i].typed ? stim_rows[i].want : r);
    end
    wait_drained();

    // Random packets: mostly well-formed, ended by a flush, with stray flushes
    // and unterminated runs mixed in so the accumulator sees every fill level.
    while (words_sent < stim_rows.size() + RandomWords) begin
      pkt_len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 48) : $urandom_range(1, 8);
      for (int unsigned k = 0; k < pkt_len; k++) begin
        cnt = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
        if (k == pkt_len - 1) eop = ($urandom_range(0, 15) != 0);
        else eop = ($urandom_range(0, 31) == 0);
        send_word(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), cnt, eop, r);
        queue_bytes(r);
      end
      // Once, midway, let the block empty out completely before going on.
      if (words_sent >= 900 && words_sent < 900 + pkt_len) wait_drained();
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    $display("Run drove %0d words and checked %0d bytes, %0d of them packet ends.",
             words_sent, bytes_checked, packet_ends);
    $display("%0d words produced a completed byte and a padded one together.", double_words);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("testbench: errors");
    $finish;
  end

endmodule
